// ===== design/pbk_pkg.sv =====
// shared types, constants and helper functions of the parabola breakpoint pipeline
package pbk_pkg;

    localparam int SQ_STEPS  = 65;    // root bits of the square root
    localparam int P_W       = 130;   // radicand width, two bits per root step
    localparam int SQ_REM_W  = 68;
    localparam int DV1_STEPS = 50;    // quotient bits of the root division
    localparam int N1_W      = 66;
    localparam int U_W       = 51;
    localparam int N2_W      = 102;
    localparam int DV2_STEPS = 33;    // quotient bits of the height division
    localparam int D2_W      = 33;

    localparam logic [U_W-1:0] U_BIG   = {1'b1, {(U_W-1){1'b0}}};
    localparam logic [31:0]    SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0]    SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] sweep_y;
        logic signed [31:0] left_focus_x;
        logic signed [31:0] left_focus_y;
        logic signed [31:0] right_focus_x;
        logic signed [31:0] right_focus_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] cross_x;
        logic signed [31:0] cross_y;
        logic               invalid;
    } t_out_item;

    // values that ride along with an item through the pipeline
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [32:0] d1;
        logic [31:0]        d1m;
        logic signed [32:0] ys;
        logic [31:0]        dym;
        logic               dyneg;
        logic signed [65:0] t;
        logic signed [32:0] hx;
        logic               inv;
        logic               lin;
        logic signed [31:0] cx;
    } t_side;

    function automatic logic [31:0] mag33(logic signed [32:0] v);
        logic signed [32:0] neg;
        neg = -v;
        return v[32] ? neg[31:0] : v[31:0];
    endfunction

    function automatic logic [31:0] sat53(logic signed [52:0] v);
        logic over;
        logic under;
        over  = !v[52] && (|v[51:31]);
        under = v[52] && !(&v[51:31]);
        return over ? SAT_MAX : (under ? SAT_MIN : v[31:0]);
    endfunction

endpackage

// ===== design/pbk_in_if.sv =====
// input channel: focus pair and sweep line
interface pbk_in_if
    import pbk_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== design/pbk_out_if.sv =====
// output channel: breakpoint coordinates and invalid flag
interface pbk_out_if
    import pbk_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== design/parabola_breakpoint.sv =====
// Parabola breakpoint unit: intersection of two beach-line parabolas.
// Input channel i_in carries the sweep line and the left and right foci
// (signed fixed point); output channel o_out returns cross_x, cross_y and
// an invalid flag, one result item for every input item, in order.
// The unit is a fully pipelined datapath: one item can be accepted in
// every cycle while the output register is not stalled. The depth is set
// by the square root (one root bit per stage, 65 stages), the root
// division (50 quotient bits) and the height division (33 quotient
// bits), plus the multiply, add and output register stages.
// Valid bits travel with the data. When the output register holds an
// item that the receiver has not taken, the whole pipeline holds and
// i_in.ready goes low; nothing is dropped or repeated. A synchronous
// active-low reset clears all valid bits; the datapath registers are not
// reset. Invalid items (focus on the sweep line, foci on opposite sides,
// identical foci) return zero coordinates with the flag set.
module parabola_breakpoint
    import pbk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbk_in_if.sink    i_in,
    pbk_out_if.source o_out
);

    logic      adv;
    logic      r_out_v;
    t_out_item r_out_item;

    assign adv         = !r_out_v || o_out.ready;
    assign i_in.ready  = adv;
    assign o_out.valid = r_out_v;
    assign o_out.item  = r_out_item;

    // ---------------- stage a: differences and the sum y1 + l
    logic               r_a_v;
    logic signed [32:0] r_a_d1, r_a_d2, r_a_dx, r_a_dy, r_a_ys;
    logic signed [31:0] r_a_x1;
    logic signed [32:0] n_a_l, n_a_x1, n_a_y1, n_a_x2, n_a_y2;

    assign n_a_l  = {i_in.item.sweep_y[31], i_in.item.sweep_y};
    assign n_a_x1 = {i_in.item.left_focus_x[31], i_in.item.left_focus_x};
    assign n_a_y1 = {i_in.item.left_focus_y[31], i_in.item.left_focus_y};
    assign n_a_x2 = {i_in.item.right_focus_x[31], i_in.item.right_focus_x};
    assign n_a_y2 = {i_in.item.right_focus_y[31], i_in.item.right_focus_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_d1 <= n_a_y1 - n_a_l;
            r_a_d2 <= n_a_y2 - n_a_l;
            r_a_dx <= n_a_x2 - n_a_x1;
            r_a_dy <= n_a_y2 - n_a_y1;
            r_a_ys <= n_a_y1 + n_a_l;
            r_a_x1 <= i_in.item.left_focus_x;
        end
    end

    // ---------------- stage b: squares and products
    logic        r_b_v;
    logic [63:0] r_b_m, r_b_dxx, r_b_dyy;
    t_side       r_b_s;
    t_side       n_b_s;
    logic [31:0] d2m, dxm;

    always_comb begin
        d2m         = mag33(r_a_d2);
        dxm         = mag33(r_a_dx);
        n_b_s.x1    = r_a_x1;
        n_b_s.d1    = r_a_d1;
        n_b_s.d1m   = mag33(r_a_d1);
        n_b_s.ys    = r_a_ys;
        n_b_s.dym   = mag33(r_a_dy);
        n_b_s.dyneg = r_a_dy[32];
        n_b_s.t     = r_a_d1 * r_a_dx;
        n_b_s.hx    = r_a_dx >>> 1;
        n_b_s.inv   = (r_a_d1 == '0) || (r_a_d2 == '0) || (r_a_d1[32] != r_a_d2[32])
                      || ((r_a_dx == '0) && (r_a_dy == '0));
        n_b_s.lin   = (r_a_dy == '0);
        n_b_s.cx    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (adv) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_m   <= n_b_s.d1m * d2m;
            r_b_dxx <= dxm * dxm;
            r_b_dyy <= n_b_s.dym * n_b_s.dym;
            r_b_s   <= n_b_s;
        end
    end

    // ---------------- stage c: squared distance
    logic        r_c_v;
    logic [64:0] r_c_dist;
    logic [63:0] r_c_m;
    t_side       r_c_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (adv) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_dist <= {1'b0, r_b_dxx} + {1'b0, r_b_dyy};
            r_c_m    <= r_b_m;
            r_c_s    <= r_b_s;
        end
    end

    // ---------------- stage d: partial products of the radicand
    logic        r_d_v;
    logic [63:0] r_d_ll, r_d_hl;
    logic [64:0] r_d_lh, r_d_hh;
    t_side       r_d_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (adv) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_ll <= r_c_m[31:0] * r_c_dist[31:0];
            r_d_lh <= r_c_m[31:0] * r_c_dist[64:32];
            r_d_hl <= r_c_m[63:32] * r_c_dist[31:0];
            r_d_hh <= r_c_m[63:32] * r_c_dist[64:32];
            r_d_s  <= r_c_s;
        end
    end

    // ---------------- square root, one root bit per stage
    logic                r_sq_v   [SQ_STEPS+1];
    logic [SQ_REM_W-1:0] r_sq_rem [SQ_STEPS+1];
    logic [SQ_STEPS-1:0] r_sq_q   [SQ_STEPS+1];
    logic [P_W-1:0]      r_sq_p   [SQ_STEPS];
    t_side               r_sq_s   [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (adv) begin
            r_sq_v[0] <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rem[0] <= '0;
            r_sq_q[0]   <= '0;
            r_sq_p[0]   <= P_W'(r_d_ll) + (P_W'(r_d_lh) << 32) + (P_W'(r_d_hl) << 32)
                           + (P_W'(r_d_hh) << 64);
            r_sq_s[0]   <= r_d_s;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        localparam int HI = P_W - 1 - 2 * k;
        logic [SQ_REM_W-1:0] rem2, trial, n_rem;
        logic                ge;

        always_comb begin
            rem2  = {r_sq_rem[k][SQ_REM_W-3:0], r_sq_p[k][HI -: 2]};
            trial = {1'b0, r_sq_q[k], 2'b01};
            ge    = rem2 >= trial;
            n_rem = ge ? rem2 - trial : rem2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_rem[k+1] <= n_rem;
                r_sq_q[k+1]   <= {r_sq_q[k][SQ_STEPS-2:0], ge};
                r_sq_s[k+1]   <= r_sq_s[k];
            end
        end

        if (k < SQ_STEPS - 1) begin : g_p
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_sq_p[k+1] <= r_sq_p[k];
                end
            end
        end
    end

    // ---------------- numerator of the root: sqrt term minus d1*dx
    logic            r_n_v;
    logic            r_n_neg;
    logic [N1_W-1:0] r_n_mag;
    t_side           r_n_s;
    logic [N1_W:0]   n_na, n_nb;

    always_comb begin
        n_na = {2'b00, r_sq_q[SQ_STEPS]} - {r_sq_s[SQ_STEPS].t[65], r_sq_s[SQ_STEPS].t};
        n_nb = {r_sq_s[SQ_STEPS].t[65], r_sq_s[SQ_STEPS].t} - {2'b00, r_sq_q[SQ_STEPS]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else if (adv) begin
            r_n_v <= r_sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n_neg <= n_na[N1_W];
            r_n_mag <= n_na[N1_W] ? n_nb[N1_W-1:0] : n_na[N1_W-1:0];
            r_n_s   <= r_sq_s[SQ_STEPS];
        end
    end

    // ---------------- root division by dy, one quotient bit per stage
    logic                 r_d1_v   [DV1_STEPS+1];
    logic [31:0]          r_d1_rem [DV1_STEPS+1];
    logic [DV1_STEPS-1:0] r_d1_q   [DV1_STEPS+1];
    logic [DV1_STEPS-1:0] r_d1_n   [DV1_STEPS];
    logic                 r_d1_big [DV1_STEPS+1];
    logic                 r_d1_neg [DV1_STEPS+1];
    t_side                r_d1_s   [DV1_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v[0] <= 1'b0;
        end else if (adv) begin
            r_d1_v[0] <= r_n_v;
        end
    end

    // quotient of 2^50 or more is clamped, far past saturation of both outputs
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1_rem[0] <= 32'(r_n_mag[N1_W-1:DV1_STEPS]);
            r_d1_big[0] <= 32'(r_n_mag[N1_W-1:DV1_STEPS]) >= r_n_s.dym;
            r_d1_q[0]   <= '0;
            r_d1_n[0]   <= r_n_mag[DV1_STEPS-1:0];
            r_d1_neg[0] <= r_n_neg ^ r_n_s.dyneg;
            r_d1_s[0]   <= r_n_s;
        end
    end

    for (genvar k = 0; k < DV1_STEPS; k++) begin : g_dv1
        logic [32:0] r2, dv, diff;
        logic [31:0] n_rem;
        logic        ge;

        always_comb begin
            r2    = {r_d1_rem[k], r_d1_n[k][DV1_STEPS-1-k]};
            dv    = {1'b0, r_d1_s[k].dym};
            ge    = r2 >= dv;
            diff  = r2 - dv;
            n_rem = ge ? diff[31:0] : r2[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_d1_v[k+1] <= r_d1_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_d1_rem[k+1] <= n_rem;
                r_d1_q[k+1]   <= {r_d1_q[k][DV1_STEPS-2:0], ge};
                r_d1_big[k+1] <= r_d1_big[k];
                r_d1_neg[k+1] <= r_d1_neg[k];
                r_d1_s[k+1]   <= r_d1_s[k];
            end
        end

        if (k < DV1_STEPS - 1) begin : g_n
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_d1_n[k+1] <= r_d1_n[k];
                end
            end
        end
    end

    // ---------------- offset u as sign and magnitude
    logic           r_u_v;
    logic [U_W-1:0] r_u_mag;
    logic           r_u_neg;
    t_side          r_u_s;
    logic           u_inc;
    logic [U_W-1:0] u_qmag;
    logic [31:0]    u_hxm;

    always_comb begin
        u_inc  = r_d1_neg[DV1_STEPS] && (r_d1_rem[DV1_STEPS] != '0);
        u_qmag = r_d1_big[DV1_STEPS] ? U_BIG
                                     : ({1'b0, r_d1_q[DV1_STEPS]} + U_W'(u_inc));
        u_hxm  = mag33(r_d1_s[DV1_STEPS].hx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_v <= 1'b0;
        end else if (adv) begin
            r_u_v <= r_d1_v[DV1_STEPS];
        end
    end

    // equal focus heights: midpoint, floor(dx / 2)
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u_mag <= r_d1_s[DV1_STEPS].lin ? U_W'(u_hxm) : u_qmag;
            r_u_neg <= r_d1_s[DV1_STEPS].lin ? r_d1_s[DV1_STEPS].hx[32] : r_d1_neg[DV1_STEPS];
            r_u_s   <= r_d1_s[DV1_STEPS];
        end
    end

    // ---------------- cross_x, partial products of u^2, d1*(y1+l)
    logic               r_w_v;
    logic [51:0]        r_w_ll;
    logic [50:0]        r_w_lh;
    logic [49:0]        r_w_hh;
    logic signed [65:0] r_w_e;
    t_side              r_w_s;
    logic signed [U_W:0] w_us;
    logic signed [52:0] w_xs;
    t_side              n_w_s;

    always_comb begin
        w_us  = r_u_neg ? -$signed({1'b0, r_u_mag}) : $signed({1'b0, r_u_mag});
        w_xs  = {{21{r_u_s.x1[31]}}, r_u_s.x1} + {w_us[U_W], w_us};
        n_w_s = r_u_s;
        n_w_s.cx = sat53(w_xs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_v <= 1'b0;
        end else if (adv) begin
            r_w_v <= r_u_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w_ll <= r_u_mag[25:0] * r_u_mag[25:0];
            r_w_lh <= r_u_mag[25:0] * r_u_mag[U_W-1:26];
            r_w_hh <= r_u_mag[U_W-1:26] * r_u_mag[U_W-1:26];
            r_w_e  <= r_u_s.d1 * r_u_s.ys;
            r_w_s  <= n_w_s;
        end
    end

    // ---------------- u^2
    logic               r_y_v;
    logic [N2_W-1:0]    r_y_u2;
    logic signed [65:0] r_y_e, r_y_ne;
    t_side              r_y_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v <= 1'b0;
        end else if (adv) begin
            r_y_v <= r_w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_y_u2 <= N2_W'(r_w_ll) + (N2_W'(r_w_lh) << 27) + (N2_W'(r_w_hh) << 52);
            r_y_e  <= r_w_e;
            r_y_ne <= -r_w_e;
            r_y_s  <= r_w_s;
        end
    end

    // ---------------- height numerator u^2 + d1*(y1+l)
    logic            r_z_v;
    logic            r_z_neg;
    logic [N2_W-1:0] r_z_mag;
    t_side           r_z_s;
    logic [N2_W:0]   z_a, z_b;

    always_comb begin
        z_a = {1'b0, r_y_u2} + {{(N2_W-65){r_y_e[65]}}, r_y_e};
        z_b = {{(N2_W-65){r_y_ne[65]}}, r_y_ne} - {1'b0, r_y_u2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_v <= 1'b0;
        end else if (adv) begin
            r_z_v <= r_y_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_z_neg <= z_a[N2_W];
            r_z_mag <= z_a[N2_W] ? z_b[N2_W-1:0] : z_a[N2_W-1:0];
            r_z_s   <= r_y_s;
        end
    end

    // ---------------- height division by 2*d1, one quotient bit per stage
    logic                 r_d2_v   [DV2_STEPS+1];
    logic [D2_W-1:0]      r_d2_rem [DV2_STEPS+1];
    logic [DV2_STEPS-1:0] r_d2_q   [DV2_STEPS+1];
    logic [DV2_STEPS-1:0] r_d2_n   [DV2_STEPS];
    logic                 r_d2_big [DV2_STEPS+1];
    logic                 r_d2_neg [DV2_STEPS+1];
    t_side                r_d2_s   [DV2_STEPS+1];
    logic [D2_W-1:0]      z_div;

    assign z_div = {r_z_s.d1m, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_v[0] <= 1'b0;
        end else if (adv) begin
            r_d2_v[0] <= r_z_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d2_rem[0] <= r_z_mag[DV2_STEPS+D2_W-1:DV2_STEPS];
            r_d2_big[0] <= r_z_mag[N2_W-1:DV2_STEPS] >= (N2_W-DV2_STEPS)'(z_div);
            r_d2_q[0]   <= '0;
            r_d2_n[0]   <= r_z_mag[DV2_STEPS-1:0];
            r_d2_neg[0] <= r_z_neg ^ r_z_s.d1[32];
            r_d2_s[0]   <= r_z_s;
        end
    end

    for (genvar k = 0; k < DV2_STEPS; k++) begin : g_dv2
        logic [D2_W:0]   r2, dv, diff;
        logic [D2_W-1:0] n_rem;
        logic            ge;

        always_comb begin
            r2    = {r_d2_rem[k], r_d2_n[k][DV2_STEPS-1-k]};
            dv    = {1'b0, r_d2_s[k].d1m, 1'b0};
            ge    = r2 >= dv;
            diff  = r2 - dv;
            n_rem = ge ? diff[D2_W-1:0] : r2[D2_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_d2_v[k+1] <= r_d2_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_d2_rem[k+1] <= n_rem;
                r_d2_q[k+1]   <= {r_d2_q[k][DV2_STEPS-2:0], ge};
                r_d2_big[k+1] <= r_d2_big[k];
                r_d2_neg[k+1] <= r_d2_neg[k];
                r_d2_s[k+1]   <= r_d2_s[k];
            end
        end

        if (k < DV2_STEPS - 1) begin : g_n
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_d2_n[k+1] <= r_d2_n[k];
                end
            end
        end
    end

    // ---------------- floor, saturation and output register
    logic                 f_inc;
    logic [DV2_STEPS:0]   f_m, f_negm;
    logic [31:0]          f_cy;
    t_out_item            n_out_item;

    always_comb begin
        f_inc  = r_d2_neg[DV2_STEPS] && (r_d2_rem[DV2_STEPS] != '0);
        f_m    = {1'b0, r_d2_q[DV2_STEPS]} + (DV2_STEPS+1)'(f_inc);
        f_negm = -f_m;
        if (r_d2_big[DV2_STEPS]) begin
            f_cy = r_d2_neg[DV2_STEPS] ? SAT_MIN : SAT_MAX;
        end else if (r_d2_neg[DV2_STEPS]) begin
            f_cy = (f_m > (DV2_STEPS+1)'(SAT_MIN)) ? SAT_MIN : f_negm[31:0];
        end else begin
            f_cy = (f_m > (DV2_STEPS+1)'(SAT_MAX)) ? SAT_MAX : f_m[31:0];
        end
        if (r_d2_s[DV2_STEPS].inv) begin
            n_out_item.cross_x = '0;
            n_out_item.cross_y = '0;
            n_out_item.invalid = 1'b1;
        end else begin
            n_out_item.cross_x = r_d2_s[DV2_STEPS].cx;
            n_out_item.cross_y = f_cy;
            n_out_item.invalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_d2_v[DV2_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item <= n_out_item;
        end
    end

    // ---------------- assertions
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_item.invalid |-> (r_out_item.cross_x == '0)
                                          && (r_out_item.cross_y == '0))
        else $error("invalid item with nonzero coordinates");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_v[SQ_STEPS] |-> r_sq_rem[SQ_STEPS] <= {2'b00, r_sq_q[SQ_STEPS], 1'b0})
        else $error("square root remainder exceeds twice the root");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d1_v[DV1_STEPS] && !r_d1_big[DV1_STEPS] && (r_d1_s[DV1_STEPS].dym != '0)
        |-> r_d1_rem[DV1_STEPS] < r_d1_s[DV1_STEPS].dym)
        else $error("root division remainder not below divisor");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !o_out.ready |=> r_out_v && $stable(r_out_item) && $stable(r_d2_v[DV2_STEPS]))
        else $error("pipeline moved during output stall");

endmodule

// ===== sim/parabola_breakpoint_tb.sv =====
// testbench of the parabola breakpoint unit: exact-arithmetic predictor, scoreboard, random traffic
module parabola_breakpoint_tb
    import pbk_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] t_wide;

    class breakpoint_board;
        t_out_item expected_q[$];
        int        errors;

        static function t_wide floor_div(t_wide n, t_wide d);
            t_wide q;
            q = n / d;
            if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
            return q;
        endfunction

        static function t_wide int_sqrt(t_wide p);
            t_wide r;
            t_wide t;
            r = 0;
            for (int b = 70; b >= 0; b--) begin
                t = r | (t_wide'(1) <<< b);
                if (t * t <= p) r = t;
            end
            return r;
        endfunction

        // magnitude capped at 2^40, then saturated to 32 bits
        static function logic [31:0] clamp_sat(t_wide v);
            t_wide lim;
            lim = t_wide'(1) <<< 40;
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            if (v > 64'sh7fff_ffff) return SAT_MAX;
            if (v < -64'sh8000_0000) return SAT_MIN;
            return v[31:0];
        endfunction

        function void note_query(t_in_item q);
            t_wide l, x1, y1, x2, y2, d1, d2, dx, dy, u, s, num;
            t_out_item r;
            l  = q.sweep_y;
            x1 = q.left_focus_x;
            y1 = q.left_focus_y;
            x2 = q.right_focus_x;
            y2 = q.right_focus_y;
            d1 = y1 - l;
            d2 = y2 - l;
            dx = x2 - x1;
            dy = y2 - y1;
            r = '0;
            if (d1 == 0 || d2 == 0 || ((d1 < 0) != (d2 < 0)) || (dx == 0 && dy == 0)) begin
                r.invalid = 1'b1;
            end else begin
                if (dy == 0) begin
                    u = floor_div(dx, 2);
                end else begin
                    s = int_sqrt(d1 * d2 * (dx * dx + dy * dy));
                    u = floor_div(s - d1 * dx, dy);
                end
                r.cross_x = clamp_sat(x1 + ((u > (t_wide'(1) <<< 40)) ? (t_wide'(1) <<< 40) :
                            (u < -(t_wide'(1) <<< 40)) ? -(t_wide'(1) <<< 40) : u));
                num = u * u + d1 * (y1 + l);
                r.cross_y = clamp_sat(floor_div(num, 2 * d1));
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_out_item a);
            t_out_item e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected item x=%h y=%h inv=%b", $time,
                         a.cross_x, a.cross_y, a.invalid);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.cross_x !== e.cross_x) begin
                $display("%0t: cross_x expected %h actual %h", $time, e.cross_x, a.cross_x);
                errors++;
            end
            if (a.cross_y !== e.cross_y) begin
                $display("%0t: cross_y expected %h actual %h", $time, e.cross_y, a.cross_y);
                errors++;
            end
            if (a.invalid !== e.invalid) begin
                $display("%0t: invalid expected %b actual %b", $time, e.invalid, a.invalid);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    pbk_in_if  in_ch();
    pbk_out_if out_ch();

    parabola_breakpoint dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    breakpoint_board board = new();
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) board.note_query(in_ch.item);
        if (i_rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.item);
    end

    // receiver: random stalls plus one long hold-off in the last phase
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold > 0) begin
                recv_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_query(t_in_item q);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= q;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_fields(logic [31:0] l, logic [31:0] x1, logic [31:0] y1,
                               logic [31:0] x2, logic [31:0] y2);
        t_in_item q;
        q.sweep_y       = l;
        q.left_focus_x  = x1;
        q.left_focus_y  = y1;
        q.right_focus_x = x2;
        q.right_focus_y = y2;
        send_query(q);
    endtask

    function automatic logic [31:0] rnd_scaled();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $signed($urandom_range(2047)) - 1024;
            2: return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
            default: return $signed($urandom_range(32'h1fff_ffff)) - 32'sh1000_0000;
        endcase
    endfunction

    // mostly foci on one side of the sweep line, some equal heights, some foci on the line, some noise
    task automatic send_random();
        logic signed [31:0] l, x1, x2, y1, y2, off;
        int kind;
        kind = $urandom_range(99);
        l  = rnd_scaled();
        x1 = rnd_scaled();
        x2 = ($urandom_range(3) == 0) ? rnd_scaled() : x1 + ($signed(rnd_scaled()) >>> 4);
        off = rnd_scaled();
        y1 = l + ((off == 0) ? 1 : off);
        y2 = ($urandom_range(1) ? l + (off >>> $urandom_range(8)) + 1 : l - (l - y1));
        if (kind < 12) y2 = y1;
        else if (kind < 16) y2 = l;
        else if (kind < 20) y1 = l;
        else if (kind < 35) begin
            y1 = $urandom();
            y2 = $urandom();
            x2 = $urandom();
        end
        send_fields(l, x1, y1, x2, y2);
    endtask

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.item    = '0;
        send_idle_pct = 18;
        recv_idle_pct = 66;
        recv_hold     = 0;
        i_rst_n       = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // focus on the sweep line, opposite sides, identical foci
        send_fields(0, 0, 32'h0001_0000, 32'h0002_0000, 0);
        send_fields(0, 0, 0, 32'h0002_0000, 32'h0001_0000);
        send_fields(0, 0, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000);
        send_fields(0, 32'h0003_0000, 32'h0002_0000, 32'h0003_0000, 32'h0002_0000);
        // equal heights, odd and negative spans
        send_fields(0, 0, 32'h0001_0000, 32'h0002_0001, 32'h0001_0000);
        send_fields(0, 32'h0002_0000, 32'h0001_0000, 32'hffff_ffff, 32'h0001_0000);
        // left higher and right higher, above and below the line
        send_fields(0, 0, 32'h0002_0000, 32'h0004_0000, 32'h0001_0000);
        send_fields(0, 0, 32'h0001_0000, 32'h0004_0000, 32'h0002_0000);
        send_fields(32'h0005_0000, 0, 32'h0001_0000, 32'h0004_0000, 32'h0003_0000);
        // field extremes, saturating results
        send_fields(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_fffe);
        send_fields(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
        send_fields(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000, 32'h7fff_ffff);
        send_fields(32'h7fff_ffff, 0, 32'h8000_0000, 0, 32'h7fff_fffe);
        send_fields(32'hffff_ffff, 32'hffff_ffff, 0, 1, 0);
        send_fields(0, 32'h8000_0000, 1, 32'h7fff_ffff, 1);
        send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h8000_0002);
        for (int i = 0; i < 600; i++) send_random();

        // sender pauses until the pipeline drains
        in_ch.valid <= 1'b0;
        while (board.expected_q.size() != 0) @(negedge i_clk);
        send_idle_pct = 66;
        recv_idle_pct = 18;
        for (int i = 0; i < 600; i++) send_random();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold     = 400;
        for (int i = 0; i < 650; i++) send_random();
        in_ch.valid <= 1'b0;

        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASS parabola_breakpoint");
        end else begin
            $display("FAIL parabola_breakpoint");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL parabola_breakpoint");
        $finish;
    end
endmodule
